// ===== rtl/rob_wt_pkg.sv =====
// Shared types, constants and helpers for the wrap-tag reorder buffer.
package rob_wt_pkg;

    localparam int DEPTH   = 64;                 // power of two
    localparam int IDX_W   = $clog2(DEPTH);
    localparam int TAG_W   = IDX_W + 1;          // index plus wrap bit
    localparam int KIND_W  = 2;
    localparam int ETYPE_W = 3;
    localparam int DEST_W  = 6;
    localparam int PC_W    = 32;
    localparam int ITAG_W  = 7;                  // width of tag ports

    typedef enum logic [KIND_W-1:0] {
        K_ISSUE  = 2'd0,
        K_MARK   = 2'd1,
        K_SQUASH = 2'd2,
        K_COMMIT = 2'd3
    } t_kind;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } t_state;

    // One stored entry: wrap bit of its tag and the issued payload.
    typedef struct packed {
        logic               wrap;
        logic               is_halt;
        logic [ETYPE_W-1:0] etype;
        logic [DEST_W-1:0]  dest;
        logic [PC_W-1:0]    pc;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic capture;   // latch the transferred item, start the entry read
        logic exec;      // apply the item and load the result register
    } t_cmd;

    // True when tag a is older than tag b.
    function automatic logic tag_older(input logic [TAG_W-1:0] a,
                                       input logic [TAG_W-1:0] b);
        logic res;
        if (a[TAG_W-1] != b[TAG_W-1]) begin
            res = (a[IDX_W-1:0] > b[IDX_W-1:0]);
        end else begin
            res = (a[IDX_W-1:0] < b[IDX_W-1:0]);
        end
        return res;
    endfunction

endpackage

// ===== rtl/reorder_buffer_wrap_tags_unit.sv =====
// Top level of the 64-entry reorder buffer with wrap-bit tags.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+-----------------------------------
//  item    | in        | i_in_valid / o_in_stall    | kind, tag, check_head, entry fields
//  result  | out       | o_out_valid / i_out_stall  | accepted ... empty_res
//
// Each item passes through a capture state that starts the entry RAM read,
// then an execute state that updates pointers and ready bits and loads the
// result register. The registered RAM read is why execute follows capture.
// Reset is synchronous, active low; it clears pointers, ready bits and halt.
// The entry RAM needs no clearing pass.
// A stalled result holds in its register; the next item is taken meanwhile
// and waits in execute until the result register frees up.
module reorder_buffer_wrap_tags_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [rob_wt_pkg::KIND_W-1:0] i_kind,
    input  logic [rob_wt_pkg::ITAG_W-1:0] i_tag,
    input  logic                          i_check_head,
    input  logic [rob_wt_pkg::ETYPE_W-1:0] i_entry_type,
    input  logic [rob_wt_pkg::DEST_W-1:0] i_dest_reg,
    input  logic                          i_is_halt,
    input  logic [rob_wt_pkg::PC_W-1:0]   i_pc,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_accepted,
    output logic [rob_wt_pkg::ITAG_W-1:0] o_assigned_tag,
    output logic                          o_committed,
    output logic [rob_wt_pkg::ETYPE_W-1:0] o_commit_type,
    output logic [rob_wt_pkg::DEST_W-1:0] o_commit_dest,
    output logic [rob_wt_pkg::PC_W-1:0]   o_commit_pc,
    output logic                          o_halt_done,
    output logic [rob_wt_pkg::DEST_W-1:0] o_halt_dest,
    output logic                          o_full_res,
    output logic                          o_empty_res
);
    import rob_wt_pkg::*;

    t_cmd cmd;

    rob_wt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd)
    );

    rob_wt_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_kind         (i_kind),
        .i_tag          (i_tag),
        .i_check_head   (i_check_head),
        .i_entry_type   (i_entry_type),
        .i_dest_reg     (i_dest_reg),
        .i_is_halt      (i_is_halt),
        .i_pc           (i_pc),
        .o_accepted     (o_accepted),
        .o_assigned_tag (o_assigned_tag),
        .o_committed    (o_committed),
        .o_commit_type  (o_commit_type),
        .o_commit_dest  (o_commit_dest),
        .o_commit_pc    (o_commit_pc),
        .o_halt_done    (o_halt_done),
        .o_halt_dest    (o_halt_dest),
        .o_full_res     (o_full_res),
        .o_empty_res    (o_empty_res)
    );

endmodule

// ===== rtl/rob_wt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module rob_wt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/rob_wt_ctrl.sv =====
// Controller: sequences capture and execute, owns the result valid.
module rob_wt_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output rob_wt_pkg::t_cmd o_cmd
);
    import rob_wt_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_in_valid) n_state = S_EXEC;
            S_EXEC: if (out_free)   n_state = S_IDLE;
            default:                n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd.capture = 1'b0;
        o_cmd.exec    = 1'b0;
        o_in_stall    = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall    = 1'b0;
                o_cmd.capture = i_in_valid;
            end
            S_EXEC: begin
                // hold until the result register can take the new result
                o_cmd.exec = out_free;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.exec) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// ===== rtl/rob_wt_dp.sv =====
// Datapath: pointers, ready bits, entry RAM and the result register.
module rob_wt_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  rob_wt_pkg::t_cmd              i_cmd,
    input  logic [rob_wt_pkg::KIND_W-1:0] i_kind,
    input  logic [rob_wt_pkg::ITAG_W-1:0] i_tag,
    input  logic                          i_check_head,
    input  logic [rob_wt_pkg::ETYPE_W-1:0] i_entry_type,
    input  logic [rob_wt_pkg::DEST_W-1:0] i_dest_reg,
    input  logic                          i_is_halt,
    input  logic [rob_wt_pkg::PC_W-1:0]   i_pc,
    output logic                          o_accepted,
    output logic [rob_wt_pkg::ITAG_W-1:0] o_assigned_tag,
    output logic                          o_committed,
    output logic [rob_wt_pkg::ETYPE_W-1:0] o_commit_type,
    output logic [rob_wt_pkg::DEST_W-1:0] o_commit_dest,
    output logic [rob_wt_pkg::PC_W-1:0]   o_commit_pc,
    output logic                          o_halt_done,
    output logic [rob_wt_pkg::DEST_W-1:0] o_halt_dest,
    output logic                          o_full_res,
    output logic                          o_empty_res
);
    import rob_wt_pkg::*;

    // control state
    logic [TAG_W-1:0]  r_head, n_head;
    logic [TAG_W-1:0]  r_tail, n_tail;
    logic [DEPTH-1:0]  r_ready;
    logic              r_halt, n_halt;
    logic [DEST_W-1:0] r_halt_dest, n_halt_dest;

    // captured item
    t_kind             r_kind;
    logic [TAG_W-1:0]  r_tag;
    logic              r_chk;
    t_entry            r_item;

    // result register
    logic               r_acc, n_acc;
    logic [TAG_W-1:0]   r_atag, n_atag;
    logic               r_com, n_com;
    logic [ETYPE_W-1:0] r_ctyp, n_ctyp;
    logic [DEST_W-1:0]  r_cdst, n_cdst;
    logic [PC_W-1:0]    r_cpc, n_cpc;
    logic               r_full, r_empty;

    logic              empty, full, mark_ok, issue_ok, commit_ok;
    logic              wr_en;
    logic [IDX_W-1:0]  rd_addr;
    t_entry            rd_data;
    t_entry            wr_data;
    logic [TAG_W-1:0]  stored_tag;

    assign empty     = (r_head == r_tail);
    assign full      = (r_head[IDX_W-1:0] == r_tail[IDX_W-1:0])
                       && (r_head[TAG_W-1] != r_tail[TAG_W-1]);
    assign mark_ok   = !r_chk || (!empty && !tag_older(r_tag, r_head));
    assign issue_ok  = !full;
    assign commit_ok = !empty && r_ready[r_head[IDX_W-1:0]];

    // commit reads the head entry, squash the entry addressed by the tag
    assign rd_addr = (t_kind'(i_kind) == K_COMMIT) ? r_head[IDX_W-1:0]
                                                   : i_tag[IDX_W-1:0];

    assign wr_en   = i_cmd.exec && (r_kind == K_ISSUE) && issue_ok;
    always_comb begin
        wr_data      = r_item;
        wr_data.wrap = r_tail[TAG_W-1];
    end

    rob_wt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_tail[IDX_W-1:0]),
        .i_wr_data (wr_data),
        .i_rd_en   (i_cmd.capture),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign stored_tag = {rd_data.wrap, r_tag[IDX_W-1:0]};

    always_comb begin
        n_head      = r_head;
        n_tail      = r_tail;
        n_halt      = r_halt;
        n_halt_dest = r_halt_dest;
        n_acc       = 1'b0;
        n_atag      = '0;
        n_com       = 1'b0;
        n_ctyp      = '0;
        n_cdst      = '0;
        n_cpc       = '0;
        unique case (r_kind)
            K_ISSUE: begin
                if (issue_ok) begin
                    n_acc  = 1'b1;
                    n_atag = r_tail;
                    n_tail = r_tail + TAG_W'(1);
                end
            end
            K_MARK: begin
                n_acc = 1'b0;
            end
            K_SQUASH: begin
                // cut the tail back to just after the stored tag
                n_tail = stored_tag + TAG_W'(1);
            end
            K_COMMIT: begin
                if (commit_ok) begin
                    n_head = r_head + TAG_W'(1);
                    n_acc  = 1'b1;
                    n_com  = 1'b1;
                    n_ctyp = rd_data.etype;
                    n_cdst = rd_data.dest;
                    n_cpc  = rd_data.pc;
                    if (rd_data.is_halt) begin
                        n_halt      = 1'b1;
                        n_halt_dest = rd_data.dest;
                    end
                end
            end
            default: begin
                n_acc = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_tail      <= '0;
            r_ready     <= '0;
            r_halt      <= 1'b0;
            r_halt_dest <= '0;
        end else if (i_cmd.exec) begin
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_halt      <= n_halt;
            r_halt_dest <= n_halt_dest;
            if ((r_kind == K_ISSUE) && issue_ok) begin
                r_ready[r_tail[IDX_W-1:0]] <= 1'b0;
            end
            if ((r_kind == K_MARK) && mark_ok) begin
                r_ready[r_tag[IDX_W-1:0]] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_kind         <= t_kind'(i_kind);
            r_tag          <= i_tag[TAG_W-1:0];
            r_chk          <= i_check_head;
            r_item.wrap    <= 1'b0;
            r_item.is_halt <= i_is_halt;
            r_item.etype   <= i_entry_type;
            r_item.dest    <= i_dest_reg;
            r_item.pc      <= i_pc;
        end
        if (i_cmd.exec) begin
            r_acc   <= n_acc;
            r_atag  <= n_atag;
            r_com   <= n_com;
            r_ctyp  <= n_ctyp;
            r_cdst  <= n_cdst;
            r_cpc   <= n_cpc;
            r_full  <= (n_head[IDX_W-1:0] == n_tail[IDX_W-1:0])
                       && (n_head[TAG_W-1] != n_tail[TAG_W-1]);
            r_empty <= (n_head == n_tail);
        end
    end

    assign o_accepted     = r_acc;
    assign o_assigned_tag = ITAG_W'(r_atag);
    assign o_committed    = r_com;
    assign o_commit_type  = r_ctyp;
    assign o_commit_dest  = r_cdst;
    assign o_commit_pc    = r_cpc;
    assign o_halt_done    = r_halt;
    assign o_halt_dest    = r_halt_dest;
    assign o_full_res     = r_full;
    assign o_empty_res    = r_empty;

endmodule

// ===== rtl/rob_wt_chk.sv =====
// Port-level checker for the reorder buffer, bound to the top level.
module rob_wt_chk (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_out_valid,
    input logic                          i_out_stall,
    input logic                          o_accepted,
    input logic [rob_wt_pkg::ITAG_W-1:0] o_assigned_tag,
    input logic                          o_committed,
    input logic [rob_wt_pkg::ETYPE_W-1:0] o_commit_type,
    input logic [rob_wt_pkg::DEST_W-1:0] o_commit_dest,
    input logic [rob_wt_pkg::PC_W-1:0]   o_commit_pc,
    input logic                          o_full_res,
    input logic                          o_empty_res
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    a_full_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_full_res && o_empty_res))
        else $error("buffer reported full and empty at once");

    a_commit_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_committed |-> o_accepted && o_assigned_tag == '0)
        else $error("retire without accepted, or with a tag");

    a_no_commit_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_committed |->
            o_commit_pc == '0 && o_commit_dest == '0 && o_commit_type == '0)
        else $error("retired payload shown without a retire");

endmodule

bind reorder_buffer_wrap_tags_unit rob_wt_chk u_rob_wt_chk (.*);
